@@ rtl/core/asl_pkg.sv @@
package asl_pkg;

  localparam logic [2:0] KIND_LABEL   = 3'd0;
  localparam logic [2:0] KIND_INSTR   = 3'd1;
  localparam logic [2:0] KIND_REG     = 3'd2;
  localparam logic [2:0] KIND_IMM     = 3'd3;
  localparam logic [2:0] KIND_COMMA   = 3'd4;
  localparam logic [2:0] KIND_NEWLINE = 3'd5;
  localparam logic [2:0] KIND_END     = 3'd6;
  localparam logic [2:0] KIND_INVALID = 3'd7;

  localparam logic [7:0] CHAR_COLON      = 8'h3A;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_LOWER_R    = 8'h72;
  localparam logic [7:0] CHAR_UPPER_R    = 8'h52;
  localparam logic [7:0] CHAR_COMMA      = 8'h2C;
  localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
  localparam logic [7:0] CHAR_NUL        = 8'h00;
  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_TAB        = 8'h09;
  localparam logic [7:0] CHAR_CR         = 8'h0D;
  localparam logic [7:0] CHAR_VT         = 8'h0B;
  localparam logic [7:0] CHAR_FF         = 8'h0C;

  localparam logic [15:0] SAT16_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } scan_out_t;

endpackage

@@ rtl/core/asl_scan.sv @@
module asl_scan import asl_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] char_in,
  output scan_out_t  result
);

  typedef enum logic [1:0] {MODE_IDLE, MODE_IDENT, MODE_IMM} mode_t;

  mode_t                     mode, mode_next;
  logic                      reg_cand, reg_cand_next;
  logic [15:0]               pend_start, pend_start_next;
  logic [15:0]               pend_len, pend_len_next;
  logic [POSITION_BITS-1:0]  pos, pos_next;

  logic        is_letter, is_digit, is_blank, is_word;
  logic [15:0] pos16, len_inc;
  logic [31:0] pos_ext;
  logic        close_hit, own_hit, done;
  token_t      close_tok, own_tok;

  always_comb begin
    is_letter = (char_in >= 8'h61 && char_in <= 8'h7A) ||
                (char_in >= 8'h41 && char_in <= 8'h5A);
    is_digit  = char_in >= 8'h30 && char_in <= 8'h39;
    is_blank  = char_in == CHAR_SPACE || char_in == CHAR_TAB || char_in == CHAR_CR ||
                char_in == CHAR_VT || char_in == CHAR_FF;
    is_word   = is_letter || is_digit || char_in == CHAR_UNDERSCORE;
    pos_ext   = 32'(pos);
    pos16     = (|pos_ext[31:16]) ? SAT16_MAX : pos_ext[15:0];
    len_inc   = (pend_len == SAT16_MAX) ? SAT16_MAX : pend_len + 16'd1;

    mode_next       = mode;
    reg_cand_next   = reg_cand;
    pend_start_next = pend_start;
    pend_len_next   = pend_len;
    close_hit       = 1'b0;
    own_hit         = 1'b0;
    done            = 1'b0;
    close_tok       = '{kind: KIND_INSTR, start: pend_start, length: pend_len, last: 1'b0};
    own_tok         = '{kind: KIND_INVALID, start: pos16, length: 16'd1, last: 1'b1};

    unique case (mode)
      MODE_IDENT: begin
        if (is_word) begin
          if (!is_digit) begin
            reg_cand_next = 1'b0;
          end
          pend_len_next = len_inc;
          done = 1'b1;
        end else if (char_in == CHAR_COLON) begin
          close_hit = 1'b1;
          close_tok.kind = KIND_LABEL;
          close_tok.length = len_inc;
          mode_next = MODE_IDLE;
          done = 1'b1;
        end else begin
          close_hit = 1'b1;
          close_tok.kind = (reg_cand && pend_len >= 16'd2) ? KIND_REG : KIND_INSTR;
          mode_next = MODE_IDLE;
        end
      end
      MODE_IMM: begin
        if (is_digit) begin
          pend_len_next = len_inc;
          done = 1'b1;
        end else begin
          close_hit = 1'b1;
          close_tok.kind = KIND_IMM;
          mode_next = MODE_IDLE;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase

    if (!done) begin
      if (is_letter) begin
        mode_next       = MODE_IDENT;
        reg_cand_next   = char_in == CHAR_LOWER_R || char_in == CHAR_UPPER_R;
        pend_start_next = pos16;
        pend_len_next   = 16'd1;
      end else if (is_digit) begin
        mode_next       = MODE_IMM;
        reg_cand_next   = 1'b0;
        pend_start_next = pos16;
        pend_len_next   = 16'd1;
      end else if (!is_blank) begin
        own_hit = 1'b1;
        if (char_in == CHAR_COMMA) begin
          own_tok.kind = KIND_COMMA;
        end else if (char_in == CHAR_NEWLINE) begin
          own_tok.kind = KIND_NEWLINE;
        end else if (char_in == CHAR_NUL) begin
          own_tok.kind = KIND_END;
        end
      end
    end

    if (mode_next == MODE_IDLE) begin
      reg_cand_next = 1'b0;
      pend_len_next = 16'd0;
    end

    if (char_in == CHAR_NUL) begin
      mode_next       = MODE_IDLE;
      reg_cand_next   = 1'b0;
      pend_start_next = 16'd0;
      pend_len_next   = 16'd0;
      pos_next        = '0;
    end else if (pos != '1) begin
      pos_next = pos + 1'b1;
    end else begin
      pos_next = pos;
    end

    result.second = own_tok;
    if (close_hit) begin
      result.first      = close_tok;
      result.first.last = !own_hit;
      result.count      = own_hit ? 2'd2 : 2'd1;
    end else begin
      result.first = own_tok;
      result.count = own_hit ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      reg_cand   <= 1'b0;
      pend_start <= 16'd0;
      pend_len   <= 16'd0;
      pos        <= '0;
    end else if (step) begin
      mode       <= mode_next;
      reg_cand   <= reg_cand_next;
      pend_start <= pend_start_next;
      pend_len   <= pend_len_next;
      pos        <= pos_next;
    end
  end

endmodule

@@ rtl/core/assembly_source_lexer_unit.sv @@
// Assembly source lexer: takes one source byte per request and returns tokens
// (kind, start offset, length, and a flag on the last token caused by that
// byte). A byte is registered on arrival and decoded from that register once
// the queue has room; its tokens are then written to the queue, from which
// they are offered. The unit takes one byte per cycle as long as its
// four-entry token queue has room for the up to two tokens that a byte can
// produce; a byte that closes a pending token and also forms its own token
// writes two queue entries. The output side drains one token per cycle, so
// sustained throughput is one byte per cycle only while each byte yields at
// most one token and the consumer does not stall; once the queue fills,
// every second token of a byte and every stalled output cycle holds the input
// back. A NUL byte ends the source and restarts positions at zero.
module assembly_source_lexer_unit import asl_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  source_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_bytes,
  output logic        last_of_run
);

  localparam int QUEUE_DEPTH = 4;

  logic        held_valid;
  logic [7:0]  held_byte;
  logic        room, step, pop, accept;
  logic [2:0]  count, count_next, count_after_pop;
  logic [1:0]  rd_ptr, wr_ptr;
  token_t      queue [QUEUE_DEPTH];
  scan_out_t   scan_res;
  token_t      head;

  asl_scan #(.POSITION_BITS(POSITION_BITS)) u_scan (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .char_in (held_byte),
    .result  (scan_res)
  );

  always_comb begin
    out_valid       = count != 3'd0;
    pop             = out_valid && !out_stall;
    count_after_pop = count - {2'b00, pop};
    room            = count_after_pop <= 3'(QUEUE_DEPTH - 2);
    step            = held_valid && room;
    in_stall        = held_valid && !room;
    accept          = in_valid && !in_stall;
    count_next      = count_after_pop + (step ? {1'b0, scan_res.count} : 3'd0);
    head            = queue[rd_ptr];
    token_kind      = head.kind;
    token_start     = head.start;
    token_bytes     = head.length;
    last_of_run     = head.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      count      <= 3'd0;
      rd_ptr     <= 2'd0;
      wr_ptr     <= 2'd0;
    end else begin
      if (accept) begin
        held_valid <= 1'b1;
      end else if (step) begin
        held_valid <= 1'b0;
      end
      count <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      if (step) begin
        wr_ptr <= wr_ptr + scan_res.count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= source_byte;
    end
    if (step && scan_res.count != 2'd0) begin
      queue[wr_ptr] <= scan_res.first;
    end
    if (step && scan_res.count == 2'd2) begin
      queue[wr_ptr + 2'd1] <= scan_res.second;
    end
  end

endmodule
